>>> sv/ctt_pkg.sv
// Package for the console teletype interface: command and operation codes,
// bit constants and the per-item result record.
// No dependencies; imported by every module of the block.
`default_nettype none

package ctt_pkg;

    // Command selector carried in s_tuser
    localparam logic [1:0] CMD_KBD  = 2'd0;
    localparam logic [1:0] CMD_PRN  = 2'd1;
    localparam logic [1:0] CMD_KEY  = 2'd2;
    localparam logic [1:0] CMD_TICK = 2'd3;

    // Keyboard side operations
    localparam logic [2:0] KOP_CLR_FLAG  = 3'd0;
    localparam logic [2:0] KOP_SKIP_FLAG = 3'd1;
    localparam logic [2:0] KOP_CLR_AC    = 3'd2;
    localparam logic [2:0] KOP_OR_BUF    = 3'd4;
    localparam logic [2:0] KOP_SET_IEN   = 3'd5;
    localparam logic [2:0] KOP_READ_BUF  = 3'd6;

    // Printer side operations
    localparam logic [2:0] POP_SET_FLAG  = 3'd0;
    localparam logic [2:0] POP_SKIP_FLAG = 3'd1;
    localparam logic [2:0] POP_CLR_FLAG  = 3'd2;
    localparam logic [2:0] POP_LOAD      = 3'd4;
    localparam logic [2:0] POP_SKIP_ANY  = 3'd5;
    localparam logic [2:0] POP_CLR_LOAD  = 3'd6;

    localparam logic [7:0]  KEY_HIGH_BIT    = 8'o200;
    localparam logic [15:0] DELAY_RESET     = 16'd950;
    localparam int          AC_W            = 12;
    localparam int          CHAR_W          = 7;
    localparam int          DELAY_W         = 16;

    // One result item
    typedef struct packed {
        logic [CHAR_W-1:0] print_char;
        logic              print_valid;
        logic              interrupt_request;
        logic              skip;
        logic [AC_W-1:0]   ac_out;
    } ctt_result_t;

endpackage

`default_nettype wire

>>> sv/ctt_core.sv
// Device state of the teletype interface and the single-pass update logic
// that turns one accepted item into its result. Depends on ctt_pkg.
`default_nettype none

module ctt_core (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    accept,
    input  wire logic [1:0]              cmd,
    input  wire logic [2:0]              op,
    input  wire logic [11:0]             ac_in,
    input  wire logic [7:0]              key_code,
    input  wire logic                    cfg_we,
    input  wire logic [15:0]             cfg_wdata,
    output ctt_pkg::ctt_result_t         result
);
    import ctt_pkg::*;

    logic               key_ready_reg,     key_ready_next;
    logic [7:0]         key_store_reg,     key_store_next;
    logic               irq_enable_reg,    irq_enable_next;
    logic               printer_ready_reg, printer_ready_next;
    logic [7:0]         printer_store_reg, printer_store_next;
    logic               print_pending_reg, print_pending_next;
    logic [DELAY_W-1:0] countdown_reg,     countdown_next;
    logic [DELAY_W-1:0] delay_reg;

    logic [DELAY_W-1:0] load_count;
    logic               start_print;

    // zero delay behaves as one tick
    assign load_count = (delay_reg == '0) ? {{(DELAY_W-1){1'b0}}, 1'b1} : delay_reg;

    // Next state and result for the item at the input
    always_comb
    begin
        key_ready_next     = key_ready_reg;
        key_store_next     = key_store_reg;
        irq_enable_next    = irq_enable_reg;
        printer_ready_next = printer_ready_reg;
        printer_store_next = printer_store_reg;
        print_pending_next = print_pending_reg;
        countdown_next     = countdown_reg;
        start_print        = 1'b0;
        result             = '0;
        result.ac_out      = ac_in;

        unique case (cmd)
            CMD_KBD:
            begin
                unique case (op)
                    KOP_CLR_FLAG:  key_ready_next = 1'b0;
                    KOP_SKIP_FLAG: result.skip = key_ready_reg;
                    KOP_CLR_AC:
                    begin
                        key_ready_next = 1'b0;
                        result.ac_out  = '0;
                    end
                    KOP_OR_BUF:    result.ac_out = ac_in | {4'b0, key_store_reg};
                    KOP_SET_IEN:   irq_enable_next = ac_in[0];
                    KOP_READ_BUF:
                    begin
                        key_ready_next = 1'b0;
                        result.ac_out  = {4'b0, key_store_reg};
                    end
                    default: ;
                endcase
            end
            CMD_PRN:
            begin
                unique case (op)
                    POP_SET_FLAG:  printer_ready_next = 1'b1;
                    POP_SKIP_FLAG: result.skip = printer_ready_reg;
                    POP_CLR_FLAG:  printer_ready_next = 1'b0;
                    POP_LOAD:      start_print = 1'b1;
                    POP_SKIP_ANY:  result.skip = printer_ready_reg | key_ready_reg;
                    POP_CLR_LOAD:
                    begin
                        printer_ready_next = 1'b0;
                        start_print        = 1'b1;
                    end
                    default: ;
                endcase
            end
            CMD_KEY:
            begin
                key_store_next = key_code | KEY_HIGH_BIT;
                key_ready_next = 1'b1;
            end
            default:
            begin
                // tick: count down a pending print
                if (print_pending_reg)
                begin
                    if (countdown_reg <= {{(DELAY_W-1){1'b0}}, 1'b1})
                    begin
                        countdown_next     = '0;
                        print_pending_next = 1'b0;
                        printer_ready_next = 1'b1;
                        result.print_valid = 1'b1;
                        result.print_char  = printer_store_reg[CHAR_W-1:0];
                    end
                    else
                    begin
                        countdown_next = countdown_reg - 1'b1;
                    end
                end
            end
        endcase

        if (start_print)
        begin
            printer_store_next = ac_in[7:0];
            countdown_next     = load_count;
            print_pending_next = 1'b1;
        end

        result.interrupt_request = irq_enable_next & (key_ready_next | printer_ready_next);
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_ready_reg     <= 1'b0;
            key_store_reg     <= '0;
            irq_enable_reg    <= 1'b1;
            printer_ready_reg <= 1'b0;
            printer_store_reg <= '0;
            print_pending_reg <= 1'b0;
            countdown_reg     <= '0;
            delay_reg         <= DELAY_RESET;
        end
        else
        begin
            if (cfg_we)
                delay_reg <= cfg_wdata;
            if (accept)
            begin
                key_ready_reg     <= key_ready_next;
                key_store_reg     <= key_store_next;
                irq_enable_reg    <= irq_enable_next;
                printer_ready_reg <= printer_ready_next;
                printer_store_reg <= printer_store_next;
                print_pending_reg <= print_pending_next;
                countdown_reg     <= countdown_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/ctt_out_stage.sv
// Result register of the teletype interface with its valid flag; takes a
// new item whenever it is empty or being drained. Depends on ctt_pkg.
`default_nettype none

module ctt_out_stage (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    load,
    input  wire ctt_pkg::ctt_result_t    result,
    input  wire logic                    out_ready,
    output logic                         out_valid,
    output logic                         can_load,
    output ctt_pkg::ctt_result_t         data
);
    import ctt_pkg::*;

    logic        valid_reg, valid_next;
    ctt_result_t data_reg;

    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign data       = data_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result;
    end

endmodule

`default_nettype wire

>>> sv/console_teletype_iot_device_unit.sv
// Console teletype interface, keyboard and printer sides.
// The result of an accepted item lands in the output register in the cycle after it is accepted.
// One item per cycle while the output register is empty or being drained; the device
// update is one pass of logic between the input handshake and the result register.
// Reset (rst_n, async low): flags and buffers cleared, interrupt enable set,
// print delay back to 950 ticks, output register empty.
`default_nettype none

module console_teletype_iot_device_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // op[2:0], ac_in[14:3], key_code[22:15], zero[23]
    input  wire logic [1:0]  s_tuser,   // cmd[1:0]
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // ac_out[11:0], skip[12], interrupt_request[13],
                                        // print_char[20:14], zero[23:21]
    output logic [0:0]       m_tuser,   // print_valid[0]
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata
);
    import ctt_pkg::*;

    logic        in_accept;
    ctt_result_t core_result;
    ctt_result_t out_data;

    assign in_accept = s_tvalid && s_tready;

    ctt_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (in_accept),
        .cmd      (s_tuser),
        .op       (s_tdata[2:0]),
        .ac_in    (s_tdata[14:3]),
        .key_code (s_tdata[22:15]),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .result   (core_result)
    );

    ctt_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (in_accept),
        .result   (core_result),
        .out_ready(m_tready),
        .out_valid(m_tvalid),
        .can_load (s_tready),
        .data     (out_data)
    );

    // result packing
    assign m_tdata = {3'b000, out_data.print_char, out_data.interrupt_request,
                      out_data.skip, out_data.ac_out};
    assign m_tuser = out_data.print_valid;

    // an accepted item always shows up at the output next cycle
    a_item_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> m_tvalid)
        else $error("accepted item did not reach the output register");

    // keyboard clear-accumulator op gives a zero accumulator
    a_kbd_clear_ac: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && s_tuser == CMD_KBD && s_tdata[2:0] == KOP_CLR_AC)
        |=> (m_tdata[11:0] == 12'd0))
        else $error("keyboard clear op returned a nonzero accumulator");

    // no printed character unless a print completed
    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[20:14] == 7'd0))
        else $error("print_char nonzero without print_valid");

    // print completion only on a tick item
    a_print_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && s_tuser != CMD_TICK) |=> !m_tuser[0])
        else $error("print completed on a non-tick item");

endmodule

`default_nettype wire

>>> sim/tb_console_teletype_iot_device_unit.sv
// Self-checking testbench for the console teletype unit: directed keyboard and
// printer operations, print delay extremes, backpressure and random traffic.
// Depends on ctt_pkg and console_teletype_iot_device_unit.
`timescale 1ns / 1ps

module tb_console_teletype_iot_device_unit;

    import ctt_pkg::*;

    // Operation codes with no effect on either side
    localparam logic [2:0] OP_SPARE_LO = 3'd3;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;   // op[2:0], ac_in[14:3], key_code[22:15], zero[23]
    logic [1:0]  s_tuser   = '0;   // cmd[1:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;          // ac_out[11:0], skip[12], interrupt_request[13],
                                   // print_char[20:14], zero[23:21]
    logic [0:0]  m_tuser;          // print_valid[0]
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = '0;

    console_teletype_iot_device_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // Device state as the predictor sees it
    logic        kbd_flag  = 1'b0;
    logic [7:0]  kbd_buf   = '0;
    logic        ien       = 1'b1;
    logic        prn_flag  = 1'b0;
    logic [7:0]  prn_buf   = '0;
    logic        prn_busy  = 1'b0;
    logic [15:0] prn_count = '0;
    logic [15:0] delay_ticks = DELAY_RESET;

    ctt_result_t pending_results[$];
    int          items_sent    = 0;
    int          results_seen  = 0;
    int          prints_seen   = 0;
    int          err_count     = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_req      = 0;
    int          hold_left     = 0;

    // Load the printer buffer and (re)start the countdown
    function automatic void start_print(logic [11:0] ac);
        prn_buf   = ac[7:0];
        prn_count = (delay_ticks == 16'd0) ? 16'd1 : delay_ticks;
        prn_busy  = 1'b1;
    endfunction

    // Apply one item to the device state and return its result
    function automatic ctt_result_t teletype_result(logic [1:0] cmd, logic [2:0] op,
                                                    logic [11:0] ac, logic [7:0] key);
        ctt_result_t r;
        r = '0;
        case (cmd)
            CMD_KBD:
                case (op)
                    KOP_CLR_FLAG:  kbd_flag = 1'b0;
                    KOP_SKIP_FLAG: r.skip = kbd_flag;
                    KOP_CLR_AC:
                    begin
                        kbd_flag = 1'b0;
                        ac = '0;
                    end
                    KOP_OR_BUF:    ac = ac | {4'b0, kbd_buf};
                    KOP_SET_IEN:   ien = ac[0];
                    KOP_READ_BUF:
                    begin
                        kbd_flag = 1'b0;
                        ac = {4'b0, kbd_buf};
                    end
                    default: ;
                endcase
            CMD_PRN:
                case (op)
                    POP_SET_FLAG:  prn_flag = 1'b1;
                    POP_SKIP_FLAG: r.skip = prn_flag;
                    POP_CLR_FLAG:  prn_flag = 1'b0;
                    POP_LOAD:      start_print(ac);
                    POP_SKIP_ANY:  r.skip = prn_flag | kbd_flag;
                    POP_CLR_LOAD:
                    begin
                        prn_flag = 1'b0;
                        start_print(ac);
                    end
                    default: ;
                endcase
            CMD_KEY:
            begin
                kbd_buf  = key | KEY_HIGH_BIT;
                kbd_flag = 1'b1;
            end
            default:
                // tick: count down a pending print
                if (prn_busy)
                begin
                    if (prn_count <= 16'd1)
                    begin
                        prn_count     = '0;
                        prn_busy      = 1'b0;
                        prn_flag      = 1'b1;
                        r.print_valid = 1'b1;
                        r.print_char  = prn_buf[6:0];
                    end
                    else
                    begin
                        prn_count = prn_count - 16'd1;
                    end
                end
        endcase
        r.ac_out            = ac;
        r.interrupt_request = ien & (kbd_flag | prn_flag);
        return r;
    endfunction

    // Receiver: random stalls, plus long hold-offs on request
    always @(posedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    // Result checker: compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin : result_check
        ctt_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: unexpected result: expected none, actual %06h/%0b",
                         $time, m_tdata, m_tuser);
                err_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (want.print_valid)
                    prints_seen++;
                check_field("ac_out", want.ac_out, m_tdata[11:0]);
                check_field("skip", want.skip, m_tdata[12]);
                check_field("interrupt_request", want.interrupt_request, m_tdata[13]);
                check_field("print_char", want.print_char, m_tdata[20:14]);
                check_field("print_valid", want.print_valid, m_tuser[0]);
            end
        end
    end

    // Offer one item, after an optional gap, and wait for it to be taken
    task automatic send_item(input logic [1:0] cmd, input logic [2:0] op,
                             input logic [11:0] ac, input logic [7:0] key);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, key, ac, op};
        do @(posedge clk); while (!s_tready);
        pending_results.push_back(teletype_result(cmd, op, ac, key));
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(CMD_TICK, 3'($urandom), 12'($urandom), 8'($urandom));
    endtask

    task automatic send_noise();
        send_item(2'($urandom), 3'($urandom), 12'($urandom), 8'($urandom));
    endtask

    // Stop offering and wait until every result has come back
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_delay(input logic [15:0] value);
        wait_drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        delay_ticks = value;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // One short driver-like exchange with random content, or a stray item
    task automatic send_random_sequence();
        int kind;
        int ticks;
        kind = $urandom_range(9);
        if (kind <= 2)
        begin
            // key arrives, poll the flag, read or merge the buffer
            send_item(CMD_KEY, 3'($urandom), 12'($urandom), 8'($urandom));
            if ($urandom_range(3) == 0)
                send_item(CMD_KEY, 3'($urandom), 12'($urandom), 8'($urandom));
            send_item(CMD_KBD, KOP_SKIP_FLAG, 12'($urandom), 8'($urandom));
            send_item(CMD_KBD, $urandom_range(1) ? KOP_READ_BUF : KOP_OR_BUF,
                      12'($urandom), 8'($urandom));
        end
        else if (kind <= 5)
        begin
            // start a print, tick it out while polling, then maybe clear
            send_item(CMD_PRN, $urandom_range(1) ? POP_LOAD : POP_CLR_LOAD,
                      12'($urandom), 8'($urandom));
            ticks = prn_count + $urandom_range(2);
            repeat (ticks)
            begin
                if ($urandom_range(4) == 0)
                    send_item(CMD_PRN, $urandom_range(1) ? POP_SKIP_FLAG : POP_SKIP_ANY,
                              12'($urandom), 8'($urandom));
                send_tick();
            end
            if ($urandom_range(1))
                send_item(CMD_PRN, POP_CLR_FLAG, 12'($urandom), 8'($urandom));
        end
        else if (kind == 6)
        begin
            send_item(CMD_KBD, KOP_SET_IEN, 12'($urandom), 8'($urandom));
        end
        else
        begin
            send_noise();
        end
    endtask

    // A print at the reset delay, before any register write
    task automatic test_reset_delay();
        send_item(CMD_PRN, POP_LOAD, 12'h3C5, 8'h00);
        while (prn_busy)
            send_tick();
        send_item(CMD_PRN, POP_SKIP_FLAG, 12'h000, 8'h00);
    endtask

    // Every operation, field extremes, overrun and restart
    task automatic test_directed_ops();
        write_delay(16'd2);
        send_item(CMD_KEY, KOP_SET_IEN, 12'hFFF, 8'h00);   // op ignored, bit 7 forced
        send_item(CMD_KBD, KOP_SKIP_FLAG, 12'h000, 8'hFF);
        send_item(CMD_KEY, KOP_CLR_FLAG, 12'h000, 8'hFF);  // overrun
        send_item(CMD_KBD, KOP_OR_BUF, 12'hF00, 8'h00);
        send_item(CMD_KBD, KOP_READ_BUF, 12'hFFF, 8'h00);
        send_item(CMD_KBD, KOP_SKIP_FLAG, 12'hFFF, 8'h00);
        send_item(CMD_KBD, KOP_CLR_AC, 12'hABC, 8'h00);
        send_item(CMD_KEY, KOP_CLR_FLAG, 12'h000, 8'h41);
        send_item(CMD_KBD, KOP_CLR_FLAG, 12'h123, 8'h00);
        send_item(CMD_KBD, OP_SPARE_LO, 12'h555, 8'h00);
        send_item(CMD_KBD, OP_SPARE_HI, 12'hAAA, 8'h00);
        send_item(CMD_KBD, KOP_SET_IEN, 12'hFFE, 8'h00);   // interrupts off
        send_item(CMD_PRN, POP_SET_FLAG, 12'h000, 8'h00);
        send_item(CMD_KBD, KOP_SET_IEN, 12'h001, 8'h00);   // back on
        send_item(CMD_PRN, POP_SKIP_FLAG, 12'h000, 8'h00);
        send_item(CMD_PRN, POP_CLR_FLAG, 12'h000, 8'h00);
        send_item(CMD_PRN, POP_SKIP_ANY, 12'h000, 8'h00);
        send_item(CMD_PRN, OP_SPARE_LO, 12'hFFF, 8'h00);
        send_item(CMD_PRN, OP_SPARE_HI, 12'h000, 8'h00);
        send_item(CMD_KEY, KOP_CLR_FLAG, 12'h000, 8'h7F);
        send_item(CMD_PRN, POP_SKIP_ANY, 12'h000, 8'h00);
        send_item(CMD_PRN, POP_LOAD, 12'hFFF, 8'h00);
        send_item(CMD_TICK, OP_SPARE_HI, 12'hFFF, 8'hFF);
        send_item(CMD_PRN, POP_CLR_LOAD, 12'h0AB, 8'h00);  // restart
        send_item(CMD_TICK, KOP_CLR_FLAG, 12'h000, 8'h00);
        send_item(CMD_TICK, KOP_CLR_FLAG, 12'h000, 8'h00); // completes
        send_item(CMD_TICK, OP_SPARE_HI, 12'h000, 8'h00);  // idle tick
    endtask

    // Zero, one and full-scale print delays
    task automatic test_delay_extremes();
        write_delay(16'd0);
        send_item(CMD_PRN, POP_LOAD, 12'hF7F, 8'h00);
        send_tick();
        write_delay(16'd1);
        send_item(CMD_PRN, POP_CLR_LOAD, 12'h080, 8'h00);
        send_tick();
        send_tick();
        // full-scale load, a few ticks, then a restart at a short delay
        write_delay(16'hFFFF);
        send_item(CMD_PRN, POP_CLR_LOAD, 12'hE5A, 8'h00);
        repeat (3)
            send_tick();
        send_item(CMD_PRN, POP_SKIP_FLAG, 12'h000, 8'h00);
        write_delay(16'd2);
        send_item(CMD_PRN, POP_LOAD, 12'h0C3, 8'h00);
        while (prn_busy)
            send_tick();
        send_item(CMD_PRN, POP_SKIP_FLAG, 12'h000, 8'h00);
    endtask

    // Long receiver hold-off so the block fills, then a full drain pause
    task automatic test_backpressure();
        write_delay(16'd3);
        set_idling(0, 0);
        hold_req = 300;
        repeat (40)
            send_random_sequence();
        wait_drain();
        repeat (20)
            send_random_sequence();
    endtask

    task automatic test_random_phase(input int send_pct, input int recv_pct,
                                     input logic [15:0] delay, input int count);
        int stop_at;
        write_delay(delay);
        set_idling(send_pct, recv_pct);
        stop_at = items_sent + count;
        while (items_sent < stop_at)
            send_random_sequence();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_delay();
        test_directed_ops();
        test_delay_extremes();
        test_backpressure();
        test_random_phase(0, 0, 16'd1, 150);
        test_random_phase(88, 0, 16'($urandom_range(12, 2)), 150);
        test_random_phase(0, 88, 16'd0, 150);
        test_random_phase(18, 18, 16'($urandom_range(30, 3)), 150);

        wait_drain();
        repeat (4) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0t ns: results left over: expected 0, actual %0d",
                     $time, pending_results.size());
            err_count++;
        end
        $display("Ran %0d items through keyboard, printer, key and tick commands;",
                 items_sent);
        $display("checked %0d results, %0d completed prints, %0d mismatching fields.",
                 results_seen, prints_seen, err_count);
        if (err_count == 0)
            $display("console_teletype_iot_device_unit: match");
        else
            $display("console_teletype_iot_device_unit: mismatch");
        $finish;
    end

    // Watchdog
    initial
    begin
        #8_000_000;
        $display("console_teletype_iot_device_unit: mismatch");
        $finish;
    end

endmodule
